/* sv/mpv_pkg.sv */
package mpv_pkg;

  localparam int CW = 38;
  localparam int ZW = 28;
  localparam int TAB_LEN = 24;
  localparam logic signed [ZW-1:0] PI_Q24 = 28'sd52707179;
  localparam logic signed [17:0] ANG_MAX = 18'sd25736;
  localparam logic [9:0] RATE_RESET = 10'd20;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_COMB,
    ST_SQ,
    ST_SQRT,
    ST_FEED,
    ST_DRAIN,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic signed [31:0] pos_in_x;
    logic signed [31:0] pos_in_y;
    logic signed [31:0] pos_in_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] ned_north;
    logic signed [31:0] ned_east;
    logic signed [31:0] ned_down;
    logic signed [31:0] vel_north;
    logic signed [31:0] vel_east;
    logic signed [31:0] vel_down;
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
  } out_t;

  typedef struct packed {
    logic                 valid;
    logic                 zero;
    logic [1:0]           tag;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  function automatic logic signed [ZW-1:0] atan_val(input int idx);
    logic signed [ZW-1:0] v;
    case (idx)
      0: v = 28'sd13176795;
      1: v = 28'sd7778716;
      2: v = 28'sd4110060;
      3: v = 28'sd2086331;
      4: v = 28'sd1047214;
      5: v = 28'sd524117;
      6: v = 28'sd262123;
      7: v = 28'sd131069;
      8: v = 28'sd65536;
      9: v = 28'sd32768;
      10: v = 28'sd16384;
      11: v = 28'sd8192;
      12: v = 28'sd4096;
      13: v = 28'sd2048;
      14: v = 28'sd1024;
      15: v = 28'sd512;
      16: v = 28'sd256;
      17: v = 28'sd128;
      18: v = 28'sd64;
      19: v = 28'sd32;
      20: v = 28'sd16;
      21: v = 28'sd8;
      22: v = 28'sd4;
      23: v = 28'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* sv/mpv_cordic_cell.sv */
module mpv_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mpv_pkg::cordic_t cell_i,
  output mpv_pkg::cordic_t cell_o
);
  import mpv_pkg::*;

  cordic_t cell_d, cell_q;
  logic signed [CW-1:0] xs, ys;

  assign xs = cell_i.x >>> STEP;
  assign ys = cell_i.y >>> STEP;

  always_comb begin
    cell_d = cell_i;
    if (!cell_i.y[CW-1]) begin
      cell_d.x = cell_i.x + ys;
      cell_d.y = cell_i.y - xs;
      cell_d.z = cell_i.z + atan_val(STEP);
    end else begin
      cell_d.x = cell_i.x - ys;
      cell_d.y = cell_i.y + xs;
      cell_d.z = cell_i.z - atan_val(STEP);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

/* sv/mpv_isqrt.sv */
module mpv_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [56:0] rad_i,
  output logic        done_o,
  output logic [28:0] root_o
);

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [56:0] v_q;
  logic [57:0] r_q;
  logic [57:0] bit_w, trial;
  logic        ge;

  assign bit_w = 58'(1) << {cnt_q, 1'b0};
  assign trial = r_q + bit_w;
  assign ge    = {1'b0, v_q} >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 5'd0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd28;
      end else if (busy_q) begin
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q - 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q <= rad_i;
      r_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        v_q <= v_q - trial[56:0];
        r_q <= (r_q >> 1) + bit_w;
      end else begin
        r_q <= r_q >> 1;
      end
    end
  end

  assign done_o = done_q;
  assign root_o = r_q[28:0];

endmodule

/* sv/mocap_pose_to_ned_with_velocity_top.sv */
// Turns one tracker pose into NED position, finite-difference velocity and
// roll/pitch/yaw. One pose is processed at a time, and the next pose is
// taken only after the result has been loaded into the output register:
// the single 16x16 multiplier forms the quaternion products one by one,
// the asin argument is combined and squared, the bit-serial square root
// runs, then 3 vectors enter a CORDIC_STEPS-deep chain of CORDIC cells,
// and the output register is loaded once the last one leaves it. The
// result sits in that register, so the next pose is taken while it waits.
// cfg_we_i writes the update rate used as the velocity scale.
module mocap_pose_to_ned_with_velocity_top #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mpv_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mpv_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic [9:0]    cfg_data_i
);
  import mpv_pkg::*;

  state_e state_q, state_d;
  logic [9:0] rate_q;
  in_t in_q;
  logic [3:0] mcnt_q;
  logic [1:0] fcnt_q;
  logic signed [31:0] pr_q [9];
  logic signed [15:0] ma, mb;
  logic signed [31:0] mp;
  logic signed [35:0] an_q, ad_q, bn_q, bd_q;
  logic signed [29:0] s_q;
  logic signed [35:0] s_w;
  logic [56:0] rad;
  logic sq_start;
  logic sq_done;
  logic [28:0] root;
  logic signed [31:0] prev_n_q, prev_e_q, prev_d_q;
  logic signed [31:0] north, east, down;
  logic signed [31:0] vn_q, ve_q, vd_q;
  logic signed [15:0] ang_q [3];
  logic out_valid_q;
  out_t out_q;
  logic accept, out_free;

  cordic_t link [CORDIC_STEPS+1];
  logic signed [CW-1:0] fx, fy;
  logic signed [ZW:0] zr_full;
  logic signed [17:0] zr;
  logic signed [15:0] ang;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= RATE_RESET;
    end else if (cfg_we_i) begin
      rate_q <= cfg_data_i;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept) state_d = ST_MUL;
      ST_MUL:   if (mcnt_q == 4'd8) state_d = ST_COMB;
      ST_COMB:  state_d = ST_SQ;
      ST_SQ:    state_d = ST_SQRT;
      ST_SQRT:  if (sq_done) state_d = ST_FEED;
      ST_FEED:  if (fcnt_q == 2'd2) state_d = ST_DRAIN;
      ST_DRAIN: if (link[CORDIC_STEPS].valid && link[CORDIC_STEPS].tag == 2'd2)
                  state_d = ST_OUT;
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    sq_start = (state_q == ST_SQ);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mcnt_q      <= '0;
      fcnt_q      <= '0;
      out_valid_q <= 1'b0;
      prev_n_q    <= '0;
      prev_e_q    <= '0;
      prev_d_q    <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_MUL) mcnt_q <= mcnt_q + 4'd1;
      else mcnt_q <= '0;
      if (state_q == ST_FEED) fcnt_q <= fcnt_q + 2'd1;
      else fcnt_q <= '0;
      if (state_q == ST_COMB) begin
        prev_n_q <= north;
        prev_e_q <= east;
        prev_d_q <= down;
      end
      if (state_q == ST_OUT && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) in_q <= in_data_i;
  end

  // quaternion products, w=q0 x=q1 z=q2 y=q3
  always_comb begin
    case (mcnt_q)
      4'd0: begin ma = in_q.quat_y; mb = in_q.quat_z; end
      4'd1: begin ma = in_q.quat_w; mb = in_q.quat_x; end
      4'd2: begin ma = in_q.quat_x; mb = in_q.quat_x; end
      4'd3: begin ma = in_q.quat_z; mb = in_q.quat_z; end
      4'd4: begin ma = in_q.quat_z; mb = in_q.quat_w; end
      4'd5: begin ma = in_q.quat_y; mb = in_q.quat_x; end
      4'd6: begin ma = in_q.quat_y; mb = in_q.quat_w; end
      4'd7: begin ma = in_q.quat_x; mb = in_q.quat_z; end
      default: begin ma = in_q.quat_w; mb = in_q.quat_w; end
    endcase
  end

  assign mp = ma * mb;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL && mcnt_q <= 4'd8) pr_q[mcnt_q] <= mp;
  end

  // position remap and velocity
  always_comb begin
    north = in_q.pos_in_z;
    east  = (in_q.pos_in_x == 32'sh8000_0000) ? 32'sh7fff_ffff : -in_q.pos_in_x;
    down  = (in_q.pos_in_y == 32'sh8000_0000) ? 32'sh7fff_ffff : -in_q.pos_in_y;
  end

  function automatic logic signed [31:0] vel(input logic signed [31:0] cur,
                                             input logic signed [31:0] prv,
                                             input logic [9:0] rate);
    logic signed [32:0] diff;
    logic signed [43:0] prod;
    diff = 33'(cur) - 33'(prv);
    prod = 44'(diff) * 44'(signed'({1'b0, rate}));
    if (prod > 44'sd2147483647) return 32'sh7fff_ffff;
    if (prod < -44'sd2147483648) return 32'sh8000_0000;
    return prod[31:0];
  endfunction

  assign s_w = 36'sd2 * (36'(pr_q[4]) - 36'(pr_q[5]));

  always_ff @(posedge clk_i) begin
    if (state_q == ST_COMB) begin
      vn_q <= vel(north, prev_n_q, rate_q);
      ve_q <= vel(east, prev_e_q, rate_q);
      vd_q <= vel(down, prev_d_q, rate_q);
      an_q <= 36'sd2 * (36'(pr_q[0]) + 36'(pr_q[1]));
      ad_q <= 36'sd268435456 - 36'sd2 * (36'(pr_q[2]) + 36'(pr_q[3]));
      bn_q <= 36'sd2 * (36'(pr_q[6]) + 36'(pr_q[7]));
      bd_q <= -36'sd268435456 + 36'sd2 * (36'(pr_q[8]) + 36'(pr_q[2]));
      if (s_w > 36'sd268435456) s_q <= 30'sd268435456;
      else if (s_w < -36'sd268435456) s_q <= -30'sd268435456;
      else s_q <= s_w[29:0];
    end
  end

  // radicand for the cosine of the asin angle
  assign rad = (57'(1) << 56) - 57'(unsigned'(60'(s_q) * 60'(s_q)));

  mpv_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sq_start),
    .rad_i  (rad),
    .done_o (sq_done),
    .root_o (root)
  );

  // vector entry, left half-plane folded by pi
  always_comb begin
    case (fcnt_q)
      2'd0: begin fx = CW'(ad_q); fy = CW'(an_q); end
      2'd1: begin fx = CW'(signed'({1'b0, root})); fy = CW'(s_q); end
      default: begin fx = CW'(bd_q); fy = CW'(bn_q); end
    endcase
    link[0].valid = (state_q == ST_FEED);
    link[0].tag   = fcnt_q;
    link[0].zero  = (fx == '0) && (fy == '0);
    link[0].x     = fx;
    link[0].y     = fy;
    link[0].z     = '0;
    if (fx[CW-1]) begin
      link[0].x = -fx;
      link[0].y = -fy;
      link[0].z = fy[CW-1] ? -PI_Q24 : PI_Q24;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    mpv_cordic_cell #(.STEP(i)) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .cell_i(link[i]),
      .cell_o(link[i+1])
    );
  end

  // round to Q13 and clamp
  always_comb begin
    zr_full = (ZW+1)'(link[CORDIC_STEPS].z) + (ZW+1)'(1024);
    zr      = 18'(zr_full >>> 11);
    if (link[CORDIC_STEPS].zero) ang = '0;
    else if (zr > ANG_MAX) ang = ANG_MAX[15:0];
    else if (zr < -ANG_MAX) ang = 16'(-ANG_MAX);
    else ang = zr[15:0];
  end

  always_ff @(posedge clk_i) begin
    if (link[CORDIC_STEPS].valid && link[CORDIC_STEPS].tag <= 2'd2) begin
      ang_q[link[CORDIC_STEPS].tag] <= ang;
    end
    if (state_q == ST_OUT && out_free) begin
      out_q.ned_north   <= north;
      out_q.ned_east    <= prev_e_q;
      out_q.ned_down    <= prev_d_q;
      out_q.vel_north   <= vn_q;
      out_q.vel_east    <= ve_q;
      out_q.vel_down    <= vd_q;
      out_q.roll_angle  <= ang_q[1];
      out_q.pitch_angle <= -ang_q[0];
      out_q.yaw_angle   <= -ang_q[2];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_chain_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    link[CORDIC_STEPS].valid |-> state_q == ST_DRAIN)
    else $error("cordic result outside drain");

  a_sqrt_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_done |-> state_q == ST_SQRT)
    else $error("square root done outside its phase");

  a_accept_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_MUL && mcnt_q == 4'd0)
    else $error("transfer did not start products");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && out_free) |=> out_valid_q && state_q == ST_IDLE)
    else $error("result not loaded");
`endif

endmodule
